// ===== hw/rtl/asmlex_pkg.sv =====
// Shared types, constants and character-class helpers for the assembly lexer.
// Used by asmlex_core, asmlex_outq and assembler_lexer; depends on nothing.
package asmlex_pkg;

  localparam int unsigned OUTQ_DEPTH = 8;
  localparam int unsigned NUM_REGS   = 6;

  // Register names, first character in the lowest byte.
  localparam logic [23:0] REG_NAMES [NUM_REGS] = '{
    24'h786165, 24'h786265, 24'h786365, 24'h786465, 24'h697365, 24'h696465
  };

  typedef enum logic [3:0] {
    KIND_IDENT, KIND_NUMBER, KIND_REG, KIND_COMMA, KIND_LBRACKET, KIND_RBRACKET,
    KIND_LBRACE, KIND_RBRACE, KIND_PLUS, KIND_MINUS, KIND_STAR, KIND_DOLLAR,
    KIND_COLON, KIND_NEWLINE, KIND_EOF, KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_NONE, CAUSE_UNKNOWN, CAUSE_QUOTE, CAUSE_PREFIX, CAUSE_OVERFLOW
  } cause_t;

  typedef enum logic [1:0] {MODE_IDLE, MODE_WORD, MODE_COMMENT} mode_t;

  typedef enum logic [1:0] {BASE_DEC, BASE_HEX, BASE_OCT, BASE_BIN} base_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  reg_index;
    logic [63:0] value;
    logic [7:0]  word_length;
    logic [63:0] word_prefix;
    cause_t      error_cause;
    logic        last;
  } tok_t;

  // Tokens produced by one transaction, in emission order.
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } push_t;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_word_byte(logic [7:0] c);
    return c inside {["0":"9"], ["a":"z"], ["A":"Z"], "_", "."};
  endfunction

  function automatic logic [7:0] digit_value(logic [7:0] c);
    logic [7:0] d;
    if (c inside {["0":"9"]}) d = c - 8'h30;
    else if (c inside {["a":"z"]}) d = c - 8'h57;
    else if (c inside {["A":"Z"]}) d = c - 8'h37;
    else d = 8'hFF;
    return d;
  endfunction

  function automatic tok_t make_tok(kind_t k, cause_t e);
    tok_t t;
    t = '0;
    t.kind = k;
    t.error_cause = e;
    return t;
  endfunction

endpackage

// ===== hw/rtl/asmlex_core.sv =====
// Lexer state and per-byte token logic: one registered byte in, zero to two tokens out.
// Depends on asmlex_pkg.
module asmlex_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  logic [7:0]        item_ch,
  input  logic              item_eot,
  output asmlex_pkg::push_t push
);

  asmlex_pkg::mode_t  mode_r,  mode_nxt;
  logic [7:0]         len_r,   len_nxt;
  logic [63:0]        bytes_r, bytes_nxt;
  logic [63:0]        acc_r,   acc_nxt;
  asmlex_pkg::base_t  base_r,  base_nxt;
  logic               stop_r,  stop_nxt;
  asmlex_pkg::cause_t fault_r, fault_nxt;

  logic [7:0]         add_len;
  logic [63:0]        add_bytes;
  logic [63:0]        add_acc;
  asmlex_pkg::base_t  add_base;
  logic               add_stop;
  asmlex_pkg::cause_t add_fault;

  asmlex_pkg::tok_t   word_tok;

  always_comb begin
    logic [7:0]  p;
    logic [7:0]  d;
    logic [7:0]  radix;
    logic [67:0] prod;
    logic        in_word;
    in_word   = (mode_r == asmlex_pkg::MODE_WORD);
    p         = in_word ? len_r : '0;
    add_bytes = in_word ? bytes_r : '0;
    add_acc   = in_word ? acc_r : '0;
    add_base  = in_word ? base_r : asmlex_pkg::BASE_DEC;
    add_stop  = in_word ? stop_r : 1'b0;
    add_fault = in_word ? fault_r : asmlex_pkg::CAUSE_NONE;
    if (p < 8'd8) add_bytes[{p[2:0], 3'b000} +: 8] = item_ch;
    add_len = (p == 8'hFF) ? p : p + 8'd1;
    d = asmlex_pkg::digit_value(item_ch);
    case (add_base)
      asmlex_pkg::BASE_HEX: radix = 8'd16;
      asmlex_pkg::BASE_OCT: radix = 8'd8;
      asmlex_pkg::BASE_BIN: radix = 8'd2;
      default:              radix = 8'd10;
    endcase
    case (add_base)
      asmlex_pkg::BASE_HEX: prod = {add_acc, 4'b0};
      asmlex_pkg::BASE_OCT: prod = {1'b0, add_acc, 3'b0};
      asmlex_pkg::BASE_BIN: prod = {3'b0, add_acc, 1'b0};
      default:              prod = {1'b0, add_acc, 3'b0} + {3'b0, add_acc, 1'b0};
    endcase
    prod = prod + {60'b0, d};
    if (asmlex_pkg::is_digit(add_bytes[7:0])) begin
      if (p == 8'd0) begin
        add_acc   = {56'b0, item_ch - 8'h30};
        add_base  = asmlex_pkg::BASE_DEC;
        add_stop  = 1'b0;
        add_fault = asmlex_pkg::CAUSE_NONE;
      end else if (p == 8'd1 && add_bytes[7:0] == "0") begin
        if (item_ch == "x") begin
          add_base = asmlex_pkg::BASE_HEX;
          add_acc  = '0;
        end else if (item_ch == "b") begin
          add_base = asmlex_pkg::BASE_BIN;
          add_acc  = '0;
        end else if (item_ch inside {["0":"7"]}) begin
          add_base = asmlex_pkg::BASE_OCT;
          add_acc  = {56'b0, item_ch - 8'h30};
        end else begin
          add_fault = asmlex_pkg::CAUSE_PREFIX;
        end
      end else if (add_fault == asmlex_pkg::CAUSE_NONE && !add_stop) begin
        if (d >= radix) begin
          add_stop = 1'b1;
        end else if (prod[67:64] != 4'b0) begin
          add_fault = asmlex_pkg::CAUSE_OVERFLOW;
        end else begin
          add_acc = prod[63:0];
        end
      end
    end
  end

  always_comb begin
    logic reg_hit;
    reg_hit  = 1'b0;
    word_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_IDENT, asmlex_pkg::CAUSE_NONE);
    word_tok.word_length = len_r;
    word_tok.word_prefix = bytes_r;
    if (asmlex_pkg::is_digit(bytes_r[7:0])) begin
      if (fault_r != asmlex_pkg::CAUSE_NONE) begin
        word_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_ERROR, fault_r);
      end else begin
        word_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_NUMBER, asmlex_pkg::CAUSE_NONE);
        word_tok.value = acc_r;
      end
    end
    for (int i = 0; i < asmlex_pkg::NUM_REGS; i++) begin
      if (!reg_hit && len_r == 8'd3 && bytes_r == {40'b0, asmlex_pkg::REG_NAMES[i]}) begin
        reg_hit  = 1'b1;
        word_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_REG, asmlex_pkg::CAUSE_NONE);
        word_tok.reg_index = 3'(i);
      end
    end
  end

  always_comb begin
    asmlex_pkg::tok_t byte_tok;
    logic             byte_v;
    logic             word_v;
    byte_tok  = asmlex_pkg::make_tok(asmlex_pkg::KIND_EOF, asmlex_pkg::CAUSE_NONE);
    byte_v    = 1'b0;
    word_v    = 1'b0;
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    bytes_nxt = bytes_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    stop_nxt  = stop_r;
    fault_nxt = fault_r;
    if (item_valid) begin
      if (item_eot || mode_r != asmlex_pkg::MODE_COMMENT) begin
        word_v = (mode_r == asmlex_pkg::MODE_WORD);
      end
      if (item_eot) begin
        byte_v    = 1'b1;
        mode_nxt  = asmlex_pkg::MODE_IDLE;
        len_nxt   = '0;
        bytes_nxt = '0;
        acc_nxt   = '0;
        base_nxt  = asmlex_pkg::BASE_DEC;
        stop_nxt  = 1'b0;
        fault_nxt = asmlex_pkg::CAUSE_NONE;
      end else if (mode_r == asmlex_pkg::MODE_COMMENT) begin
        if (item_ch == 8'h0A) begin
          byte_v   = 1'b1;
          byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_NEWLINE, asmlex_pkg::CAUSE_NONE);
          mode_nxt = asmlex_pkg::MODE_IDLE;
        end
      end else if (word_v && asmlex_pkg::is_word_byte(item_ch)) begin
        word_v    = 1'b0;
        len_nxt   = add_len;
        bytes_nxt = add_bytes;
        acc_nxt   = add_acc;
        base_nxt  = add_base;
        stop_nxt  = add_stop;
        fault_nxt = add_fault;
      end else begin
        mode_nxt  = asmlex_pkg::MODE_IDLE;
        len_nxt   = '0;
        bytes_nxt = '0;
        acc_nxt   = '0;
        base_nxt  = asmlex_pkg::BASE_DEC;
        stop_nxt  = 1'b0;
        fault_nxt = asmlex_pkg::CAUSE_NONE;
        byte_v    = 1'b1;
        case (item_ch) inside
          8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h20: byte_v = 1'b0;
          ";": begin
            byte_v   = 1'b0;
            mode_nxt = asmlex_pkg::MODE_COMMENT;
          end
          8'h22, 8'h27:
            byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_ERROR, asmlex_pkg::CAUSE_QUOTE);
          ",": byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_COMMA, asmlex_pkg::CAUSE_NONE);
          "[": byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_LBRACKET, asmlex_pkg::CAUSE_NONE);
          "]": byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_RBRACKET, asmlex_pkg::CAUSE_NONE);
          "{": byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_LBRACE, asmlex_pkg::CAUSE_NONE);
          "}": byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_RBRACE, asmlex_pkg::CAUSE_NONE);
          "+": byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_PLUS, asmlex_pkg::CAUSE_NONE);
          "-": byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_MINUS, asmlex_pkg::CAUSE_NONE);
          "*": byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_STAR, asmlex_pkg::CAUSE_NONE);
          "$": byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_DOLLAR, asmlex_pkg::CAUSE_NONE);
          ":": byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_COLON, asmlex_pkg::CAUSE_NONE);
          8'h0A:
            byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_NEWLINE, asmlex_pkg::CAUSE_NONE);
          default: begin
            if (asmlex_pkg::is_word_byte(item_ch)) begin
              byte_v    = 1'b0;
              mode_nxt  = asmlex_pkg::MODE_WORD;
              len_nxt   = add_len;
              bytes_nxt = add_bytes;
              acc_nxt   = add_acc;
              base_nxt  = add_base;
              stop_nxt  = add_stop;
              fault_nxt = add_fault;
            end else begin
              byte_tok = asmlex_pkg::make_tok(asmlex_pkg::KIND_ERROR,
                                              asmlex_pkg::CAUSE_UNKNOWN);
            end
          end
        endcase
      end
    end
    byte_tok.last = 1'b1;
    push.count  = {1'b0, word_v} + {1'b0, byte_v};
    push.first  = word_v ? word_tok : byte_tok;
    push.second = byte_tok;
    if (word_v && !byte_v) push.first.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= asmlex_pkg::MODE_IDLE;
      len_r   <= '0;
      bytes_r <= '0;
      acc_r   <= '0;
      base_r  <= asmlex_pkg::BASE_DEC;
      stop_r  <= 1'b0;
      fault_r <= asmlex_pkg::CAUSE_NONE;
    end else begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      bytes_r <= bytes_nxt;
      acc_r   <= acc_nxt;
      base_r  <= base_nxt;
      stop_r  <= stop_nxt;
      fault_r <= fault_nxt;
    end
  end

endmodule

// ===== hw/rtl/asmlex_outq.sv =====
// Token output queue: takes up to two tokens per cycle, presents one per cycle while head_ready is high.
// Depends on asmlex_pkg.
module asmlex_outq #(
  parameter int unsigned DEPTH = asmlex_pkg::OUTQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  asmlex_pkg::push_t push,
  output asmlex_pkg::tok_t  head,
  output logic              head_valid,
  input  logic              head_ready,
  output logic              room
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  asmlex_pkg::tok_t mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r,  count_nxt;
  logic [AW-1:0]    wr_ptr1;
  logic             pop;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign pop        = head_valid && head_ready;
  assign room       = (count_r <= CW'(DEPTH - 4));
  assign wr_ptr1    = ptr_inc(wr_ptr_r);

  always_comb begin
    case (push.count)
      2'd0:    wr_ptr_nxt = wr_ptr_r;
      2'd1:    wr_ptr_nxt = wr_ptr1;
      default: wr_ptr_nxt = ptr_inc(wr_ptr1);
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wr_ptr_r] <= push.first;
    if (push.count == 2'd2) mem_r[wr_ptr1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/assembler_lexer.sv =====
// Top level of the streaming assembly lexer: input register, lexer core, token queue.
// Depends on asmlex_pkg, asmlex_core and asmlex_outq.
//
//   Channel  Ports                                   Transaction
//   in       in_valid/in_ready, in_ch, in_end_of_text   one source byte or end-of-text mark
//   out      out_valid/out_ready, out_kind ... out_last one token
//
// A byte is taken every cycle while the token queue has room for two more tokens
// beyond the tokens of the byte held in the input register; its tokens are formed from
// the input register, written into the queue and then shown at the output.
// Sustained rate is one byte per cycle, bounded by the queue draining one token per cycle.
// Reset (rst_n low, synchronous) empties the queue and returns the lexer to idle.
// A stalled output only fills the queue; the input side stops when it is nearly full.
module assembler_lexer #(
  parameter int unsigned OUTQ_DEPTH = asmlex_pkg::OUTQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [2:0]  out_reg_index,
  output logic [63:0] out_value,
  output logic [7:0]  out_word_length,
  output logic [63:0] out_word_prefix,
  output logic [2:0]  out_error_cause,
  output logic        out_last
);

  logic              stage_valid_r;
  logic [7:0]        stage_ch_r;
  logic              stage_eot_r;
  logic              room;
  asmlex_pkg::push_t push;
  asmlex_pkg::tok_t  head;

  assign in_ready = room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_ch_r  <= in_ch;
      stage_eot_r <= in_end_of_text;
    end
  end

  asmlex_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (stage_valid_r),
    .item_ch    (stage_ch_r),
    .item_eot   (stage_eot_r),
    .push       (push)
  );

  asmlex_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .head       (head),
    .head_valid (out_valid),
    .head_ready (out_ready),
    .room       (room)
  );

  assign out_kind        = head.kind;
  assign out_reg_index   = head.reg_index;
  assign out_value       = head.value;
  assign out_word_length = head.word_length;
  assign out_word_prefix = head.word_prefix;
  assign out_error_cause = head.error_cause;
  assign out_last        = head.last;

endmodule
